### sv/hbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants for the HTTP body deframer
// Payload structs, phase and status codes, register indexes, hex decode.
// ----------------------------------------------------------------------------
package hbd_pkg;

  // Size lines of this many bytes without CR are rejected
  localparam int unsigned MAX_SIZE_LINE = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_HT = 8'h09;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  // Configuration register indexes
  localparam logic CFG_BODY_ENCODING = 1'b0;
  localparam logic CFG_PAYLOAD_LEN   = 1'b1;

  // body_encoding codes
  localparam logic [1:0] ENC_IDENTITY = 2'd0;
  localparam logic [1:0] ENC_CHUNKED  = 2'd1;
  localparam logic [1:0] ENC_NO_BODY  = 2'd2;

  // body_status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_IDENT   = 3'd1,
    PH_SIZE    = 3'd2,
    PH_SIZE_LF = 3'd3,
    PH_DATA    = 3'd4,
    PH_TRAIL_A = 3'd5,
    PH_TRAIL_B = 3'd6,
    PH_STOP    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
  } hbd_in_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       byte_valid;
    logic [1:0] body_status;
  } hbd_out_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

### sv/http_body_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_body_deframer: HTTP message body deframer, one byte per cycle while not stalled
// Strips identity / chunked framing from a body byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one raw body byte per transaction; start_of_body marks the first
//            byte of a new body and samples body_encoding / payload length.
//   out_*  : zero or one result per input transaction: a payload byte, the
//            body-complete marker (status 1) or a format error (status 2).
//            Framing bytes (size lines, CR LF, chunk trailers) give nothing.
//   cfg_*  : register writes, always ready; write only while the block is
//            idle (all results delivered, pipeline drained).
// Pipeline: a byte is registered in the input register, then decoded into
//   the result register (or into the skid entry while a result waits);
//   out_valid rises when the result register is loaded.
// Throughput: one byte per cycle while in_stall is low. The only loop is
//   the per-byte decode state update.
// Stall: a result register plus one skid entry sit on the output side, so
//   intake continues while one result waits; in_stall rises only when the
//   skid entry is full and a byte is waiting to be decoded.
// Reset: synchronous, active low; clears the pipeline, the phase (idle,
//   waiting for start_of_body) and both configuration registers.
// ----------------------------------------------------------------------------
module http_body_deframer
  import hbd_pkg::*;
#(
  parameter int unsigned SIZE_LINE_MAX = MAX_SIZE_LINE
)
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  hbd_in_t     in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output hbd_out_t    out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  localparam logic [5:0] LINE_LIMIT = 6'(SIZE_LINE_MAX);

  // configuration
  logic [1:0]  body_encoding_r;
  logic [30:0] payload_len_r;

  // input register
  logic        in_valid_r;
  hbd_in_t     in_r;

  // decode state
  phase_t      phase_r,           phase_nxt;
  logic [31:0] size_value_r,      size_value_nxt;
  logic [31:0] remaining_count_r, remaining_count_nxt;
  logic [5:0]  line_pos_r,        line_pos_nxt;
  logic [3:0]  digit_count_r,     digit_count_nxt;
  logic        in_extension_r,    in_extension_nxt;

  // result register and skid entry
  logic        out_valid_r, skid_valid_r;
  hbd_out_t    out_r, skid_r;

  logic        in_accept, proc, take;
  logic        res_valid;
  hbd_out_t    res;
  logic        ended;
  logic [4:0]  hexd;
  logic        blank;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the skid entry is free whenever a byte is decoded, so its result always
  // has a place to go
  assign proc      = in_valid_r && !skid_valid_r;
  assign in_stall  = in_valid_r && skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign take      = out_valid_r && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_encoding_r <= ENC_IDENTITY;
      payload_len_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BODY_ENCODING: body_encoding_r <= cfg_data[1:0];
        CFG_PAYLOAD_LEN:   payload_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
  end

  // per-byte decode
  always_comb begin
    phase_nxt           = phase_r;
    size_value_nxt      = size_value_r;
    remaining_count_nxt = remaining_count_r;
    line_pos_nxt        = line_pos_r;
    digit_count_nxt     = digit_count_r;
    in_extension_nxt    = in_extension_r;
    res_valid           = 1'b0;
    res                 = '{body_byte: 8'h00, byte_valid: 1'b0, body_status: ST_RUN};
    ended               = 1'b0;
    hexd                = hex_decode(in_r.data_byte);
    blank               = in_r.data_byte inside {CHAR_SP, [CHAR_HT:CHAR_FF]};

    if (in_r.start_of_body) begin
      size_value_nxt      = '0;
      line_pos_nxt        = '0;
      digit_count_nxt     = '0;
      in_extension_nxt    = 1'b0;
      remaining_count_nxt = '0;
      if (body_encoding_r == ENC_CHUNKED) begin
        phase_nxt = PH_SIZE;
      end else if (body_encoding_r == ENC_IDENTITY && payload_len_r != '0) begin
        remaining_count_nxt = {1'b0, payload_len_r};
        phase_nxt           = PH_IDENT;
      end else begin
        // no body, zero length, or unused encoding code
        phase_nxt       = PH_STOP;
        res_valid       = 1'b1;
        res.body_status = ST_DONE;
        ended           = 1'b1;
      end
    end

    if (!ended) begin
      case (phase_nxt)
        PH_IDENT: begin
          remaining_count_nxt = remaining_count_nxt - 32'd1;
          res_valid           = 1'b1;
          res.body_byte       = in_r.data_byte;
          res.byte_valid      = 1'b1;
          if (remaining_count_nxt == '0) begin
            phase_nxt       = PH_STOP;
            res.body_status = ST_DONE;
          end
        end
        PH_SIZE: begin
          if (in_r.data_byte == CHAR_CR) begin
            if (digit_count_nxt == '0) begin
              phase_nxt       = PH_STOP;
              res_valid       = 1'b1;
              res.body_status = ST_ERR;
            end else begin
              phase_nxt = PH_SIZE_LF;
            end
          end else begin
            line_pos_nxt = line_pos_nxt + 6'd1;
            if (line_pos_nxt >= LINE_LIMIT) begin
              phase_nxt       = PH_STOP;
              res_valid       = 1'b1;
              res.body_status = ST_ERR;
            end else if (!in_extension_nxt) begin
              if (hexd[4]) begin
                if (digit_count_nxt >= 4'd8) begin
                  phase_nxt       = PH_STOP;
                  res_valid       = 1'b1;
                  res.body_status = ST_ERR;
                end else begin
                  size_value_nxt  = {size_value_nxt[27:0], hexd[3:0]};
                  digit_count_nxt = digit_count_nxt + 4'd1;
                end
              end else if (!(digit_count_nxt == '0 && blank)) begin
                in_extension_nxt = 1'b1;
              end
            end
          end
        end
        PH_SIZE_LF: begin
          if (in_r.data_byte != CHAR_LF) begin
            phase_nxt       = PH_STOP;
            res_valid       = 1'b1;
            res.body_status = ST_ERR;
          end else if (size_value_nxt == '0) begin
            phase_nxt       = PH_STOP;
            res_valid       = 1'b1;
            res.body_status = ST_DONE;
          end else begin
            remaining_count_nxt = size_value_nxt;
            phase_nxt           = PH_DATA;
          end
        end
        PH_DATA: begin
          remaining_count_nxt = remaining_count_nxt - 32'd1;
          if (remaining_count_nxt == '0) begin
            phase_nxt = PH_TRAIL_A;
          end
          res_valid      = 1'b1;
          res.body_byte  = in_r.data_byte;
          res.byte_valid = 1'b1;
        end
        PH_TRAIL_A: begin
          phase_nxt = PH_TRAIL_B;
        end
        PH_TRAIL_B: begin
          size_value_nxt   = '0;
          line_pos_nxt     = '0;
          digit_count_nxt  = '0;
          in_extension_nxt = 1'b0;
          phase_nxt        = PH_SIZE;
        end
        default: ;
      endcase
    end
  end

  // decode state, committed once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      size_value_r      <= '0;
      remaining_count_r <= '0;
      line_pos_r        <= '0;
      digit_count_r     <= '0;
      in_extension_r    <= 1'b0;
    end else if (proc) begin
      phase_r           <= phase_nxt;
      size_value_r      <= size_value_nxt;
      remaining_count_r <= remaining_count_nxt;
      line_pos_r        <= line_pos_nxt;
      digit_count_r     <= digit_count_nxt;
      in_extension_r    <= in_extension_nxt;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (proc && res_valid) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the result register is empty");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDENT || phase_r == PH_DATA) |-> remaining_count_r != '0)
    else $error("payload phase entered with zero bytes remaining");

  a_quiet_when_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !in_r.start_of_body && (phase_r == PH_IDLE || phase_r == PH_STOP))
      |-> !res_valid)
    else $error("result produced outside a body");

  a_no_byte_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.byte_valid |-> out_r.body_status != ST_ERR)
    else $error("payload byte flagged as format error");

endmodule

### test/tb_http_body_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_body_deframer: self-checking testbench for the HTTP body deframer
// Feeds identity, chunked and no-body streams (well-formed, broken and noise),
// predicts every result in a scoreboard and compares field by field, with
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_http_body_deframer;
  import hbd_pkg::*;

  // body_encoding code 3 is reserved and behaves like no body
  localparam logic [1:0] ENC_RESERVED = 2'd3;
  localparam logic [7:0] CHAR_VT      = 8'h0B;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;

  // ways a chunked body can be broken
  typedef enum int {
    FAULT_NONE, FAULT_EMPTY, FAULT_LONG, FAULT_DIGITS,
    FAULT_LINE_END, FAULT_HUGE, FAULT_CUT
  } fault_t;

  // --------------------------------------------------------------------------
  // Scoreboard: carries its own copy of the deframer state and registers,
  // turns each accepted byte into the expected result (if any) and checks
  // results in order against the queue of due results.
  // --------------------------------------------------------------------------
  class deframer_scoreboard;
    logic [1:0]  enc;
    logic [30:0] clen;
    phase_t      phase;
    logic [31:0] size_val;
    logic [31:0] remaining;
    logic [5:0]  line_pos;
    logic [3:0]  digits;
    bit          in_ext;
    hbd_out_t    due_results[$];
    int          mismatches;
    int          live_bytes;   // bytes the block acts on (not ignored ones)

    function new();
      enc = ENC_IDENTITY;
      clen = '0;
      phase = PH_IDLE;
      remaining = '0;
      mismatches = 0;
      live_bytes = 0;
      clear_line();
    endfunction

    function void clear_line();
      size_val = '0;
      line_pos = '0;
      digits = '0;
      in_ext = 1'b0;
    endfunction

    function void set_reg(input logic idx, input logic [30:0] val);
      if (idx == CFG_BODY_ENCODING) enc = val[1:0];
      else clen = val;
    endfunction

    function bit hex_nibble(input logic [7:0] b, output logic [3:0] n);
      n = '0;
      if (b inside {[8'h30:8'h39]}) begin
        n = b[3:0];
        return 1'b1;
      end
      // 'A'..'F' and 'a'..'f' share low nibbles 1..6
      if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
        n = b[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit conclude(input logic [1:0] status, output hbd_out_t res);
      phase = PH_STOP;
      res = '0;
      res.body_status = status;
      return 1'b1;
    endfunction

    // one size-line byte in chunked mode
    function bit size_line_byte(input logic [7:0] b, output hbd_out_t res);
      logic [3:0] nib;
      res = '0;
      if (b == CHAR_CR) begin
        if (digits == 0) return conclude(ST_ERR, res);
        phase = PH_SIZE_LF;
        return 1'b0;
      end
      line_pos = line_pos + 6'd1;
      if (line_pos >= MAX_SIZE_LINE) return conclude(ST_ERR, res);
      if (in_ext) return 1'b0;
      if (hex_nibble(b, nib)) begin
        if (digits >= 4'd8) return conclude(ST_ERR, res);
        size_val = {size_val[27:0], nib};
        digits = digits + 4'd1;
        return 1'b0;
      end
      // blanks ahead of the first digit are skipped
      if (digits == 0 && (b == CHAR_SP || (b >= CHAR_HT && b <= CHAR_FF))) return 1'b0;
      in_ext = 1'b1;
      return 1'b0;
    endfunction

    // advance the state by one byte; returns 1 when a result is due
    function bit deframe_byte(input hbd_in_t it, output hbd_out_t res);
      logic [7:0] b;
      b = it.data_byte;
      res = '0;
      if (it.start_of_body) begin
        clear_line();
        remaining = '0;
        if (enc == ENC_CHUNKED) begin
          phase = PH_SIZE;
        end else if (enc == ENC_IDENTITY) begin
          if (clen == 0) return conclude(ST_DONE, res);
          remaining = {1'b0, clen};
          phase = PH_IDENT;
        end else begin
          return conclude(ST_DONE, res);
        end
      end
      case (phase)
        PH_IDENT: begin
          remaining = remaining - 32'd1;
          res.body_byte = b;
          res.byte_valid = 1'b1;
          if (remaining == 0) begin
            phase = PH_STOP;
            res.body_status = ST_DONE;
          end else begin
            res.body_status = ST_RUN;
          end
          return 1'b1;
        end
        PH_SIZE: return size_line_byte(b, res);
        PH_SIZE_LF: begin
          if (b != CHAR_LF) return conclude(ST_ERR, res);
          if (size_val == 0) return conclude(ST_DONE, res);
          remaining = size_val;
          phase = PH_DATA;
          return 1'b0;
        end
        PH_DATA: begin
          remaining = remaining - 32'd1;
          if (remaining == 0) phase = PH_TRAIL_A;
          res.body_byte = b;
          res.byte_valid = 1'b1;
          res.body_status = ST_RUN;
          return 1'b1;
        end
        PH_TRAIL_A: begin
          phase = PH_TRAIL_B;
          return 1'b0;
        end
        PH_TRAIL_B: begin
          clear_line();
          phase = PH_SIZE;
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_byte(input hbd_in_t it);
      hbd_out_t res;
      if (it.start_of_body || !(phase inside {PH_IDLE, PH_STOP})) live_bytes++;
      if (deframe_byte(it, res)) due_results.push_back(res);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task report(input string msg);
      if (mismatches < 40) $display("[%0t] ERROR: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(input hbd_out_t got);
      hbd_out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = due_results.pop_front();
      if (got.body_byte !== want.body_byte)
        report($sformatf("body_byte %h, want %h", got.body_byte, want.body_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.body_status !== want.body_status)
        report($sformatf("body_status %0d, want %0d", got.body_status, want.body_status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  hbd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hbd_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  http_body_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframer_scoreboard sb;

  int          tx_idle_pct = 28;   // sender idles this many cycles in 100
  int          rx_idle_pct = 86;   // receiver stalls this many cycles in 100
  int          hold_cycles = 0;    // long receiver hold-off still to run
  bit          fresh = 1'b0;       // next byte carries start_of_body
  logic [1:0]  cur_enc = ENC_IDENTITY;
  logic [30:0] cur_len = '0;

  // --------------------------------------------------------------------------
  // Monitor: values sampled at the edge are the pre-edge ones, so both
  // transaction sides are seen race-free here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver: random stalls, plus the long hold-off counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Hard limit on the run, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("http_body_deframer: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // one byte transaction; the start flag is taken from 'fresh'
  task automatic put(input logic [7:0] b);
    hbd_in_t it;
    it.data_byte = b;
    it.start_of_body = fresh;
    fresh = 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering bytes and wait until every due result is out; first wait
  // for the clock so the last byte is surely noted, then let the pipe drain
  // bytes that give no result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == CFG_BODY_ENCODING) cur_enc = val[1:0];
    else cur_len = val;
  endtask

  // write only when the register would change
  task automatic use_reg(input logic idx, input logic [30:0] val);
    if (idx == CFG_BODY_ENCODING ? (cur_enc != val[1:0]) : (cur_len != val))
      write_reg(idx, val);
  endtask

  // --------------------------------------------------------------------------
  // Byte generators
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + (n - 4'd10);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0: return CHAR_SP;
      1: return CHAR_HT;
      2: return CHAR_LF;
      3: return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  function automatic logic [7:0] any_but_cr();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CHAR_CR) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CHAR_LF) b = 8'($urandom_range(255));
    return b;
  endfunction

  // size line: optional blanks, hex digits (maybe zero-padded), optional
  // extension, CR LF
  task automatic put_size_line(input logic [31:0] val);
    int nd;
    int total;
    for (int k = 1; k < 8; k++) if ((val >> (4 * k)) != 0) nd = k + 1;
    if (val < 32'h10) nd = 1;
    total = ($urandom_range(3) == 0) ? $urandom_range(nd, 8) : nd;
    repeat ($urandom_range(0, 2)) put(blank_char());
    for (int k = total - 1; k >= 0; k--) put(hex_char(val[4 * k +: 4]));
    if ($urandom_range(3) == 0) begin
      put(CHAR_SEMI);
      repeat ($urandom_range(0, 5)) put(any_but_cr());
    end
    put(CHAR_CR);
    put(CHAR_LF);
  endtask

  task automatic good_chunk();
    int sz;
    sz = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    put_size_line(sz);
    repeat (sz) put(8'($urandom_range(255)));
    // trailer bytes are skipped unchecked, so they need not be CR LF
    if ($urandom_range(3) != 0) begin
      put(CHAR_CR);
      put(CHAR_LF);
    end else begin
      put(8'($urandom_range(255)));
      put(8'($urandom_range(255)));
    end
  endtask

  task automatic chunked_body();
    fault_t fault;
    use_reg(CFG_BODY_ENCODING, 31'(ENC_CHUNKED));
    fault = ($urandom_range(4) == 0) ? fault_t'($urandom_range(1, 6)) : FAULT_NONE;
    fresh = 1'b1;
    repeat ($urandom_range(0, 3)) good_chunk();
    case (fault)
      FAULT_NONE: put_size_line(32'd0);           // last chunk ends the body
      FAULT_EMPTY: begin                           // CR before any digit
        repeat ($urandom_range(0, 2)) put(blank_char());
        if ($urandom_range(1)) put(CHAR_SEMI);
        put(CHAR_CR);
      end
      FAULT_LONG: begin                            // no CR within the line limit
        if ($urandom_range(1)) begin
          put(8'h31);
          put(CHAR_SEMI);
          repeat (30 + $urandom_range(0, 3)) put(any_but_cr());
        end else begin
          repeat (MAX_SIZE_LINE + $urandom_range(0, 2)) put(CHAR_SP);
        end
      end
      FAULT_DIGITS: repeat (9 + $urandom_range(0, 2)) put(hex_char(4'($urandom_range(15))));
      FAULT_LINE_END: begin                        // CR then something else
        put(hex_char(4'($urandom_range(1, 15))));
        put(CHAR_CR);
        put(($urandom_range(1) == 0) ? CHAR_CR : any_but_lf());
      end
      FAULT_HUGE: begin                            // 8-digit size, body cut short
        put_size_line({1'b1, 31'($urandom())});
        repeat ($urandom_range(1, 6)) put(8'($urandom_range(255)));
      end
      default: begin                               // cut off inside the size line
        put(hex_char(4'($urandom_range(15))));
        if ($urandom_range(1)) put(CHAR_CR);
      end
    endcase
    // anything after the end or an error is ignored
    repeat ($urandom_range(0, 2)) put(8'($urandom_range(255)));
  endtask

  task automatic identity_body();
    logic [30:0] len;
    int          n;
    case ($urandom_range(19))
      0: len = '0;
      1: len = 31'h7FFF_FFFF;
      2: len = 31'($urandom());
      default: len = 31'($urandom_range(1, 12));
    endcase
    use_reg(CFG_BODY_ENCODING, 31'(ENC_IDENTITY));
    use_reg(CFG_PAYLOAD_LEN, len);
    if (len == 0) n = $urandom_range(1, 3);
    else if (len > 40) n = $urandom_range(1, 6);          // restarted before the end
    else if ($urandom_range(9) == 0) n = $urandom_range(1, len);
    else n = len + $urandom_range(0, 2);
    fresh = 1'b1;
    repeat (n) put(8'($urandom_range(255)));
  endtask

  task automatic no_body();
    use_reg(CFG_BODY_ENCODING, 31'($urandom_range(1) ? ENC_NO_BODY : ENC_RESERVED));
    fresh = 1'b1;
    repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
  endtask

  // raw bytes under whatever mode is set, now and then with a start
  task automatic line_noise();
    repeat ($urandom_range(1, 6)) begin
      fresh = ($urandom_range(7) == 0);
      put(8'($urandom_range(255)));
    end
  endtask

  task automatic random_body();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) chunked_body();
    else if (pick < 78) identity_body();
    else if (pick < 88) no_body();
    else line_noise();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int goal;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity with extreme bytes, a byte before any start, and
    // bytes past the end
    write_reg(CFG_BODY_ENCODING, 31'(ENC_IDENTITY));
    write_reg(CFG_PAYLOAD_LEN, 31'd2);
    put(8'h55);
    fresh = 1'b1;
    put(8'h00);
    put(8'hFF);
    put(8'h12);
    // zero length ends on the start byte
    write_reg(CFG_PAYLOAD_LEN, '0);
    fresh = 1'b1;
    put(8'hA5);
    // largest length, body abandoned
    write_reg(CFG_PAYLOAD_LEN, 31'h7FFF_FFFF);
    fresh = 1'b1;
    put(8'h80);
    put(8'h01);
    // chunked: leading blank, extension, one data byte, zero size
    write_reg(CFG_BODY_ENCODING, 31'(ENC_CHUNKED));
    fresh = 1'b1;
    put(CHAR_SP);
    put("1");
    put(CHAR_SEMI);
    put("x");
    put(CHAR_CR);
    put(CHAR_LF);
    put("Z");
    put(CHAR_CR);
    put(CHAR_LF);
    put("0");
    put(CHAR_CR);
    put(CHAR_LF);
    // no body and the reserved code
    write_reg(CFG_BODY_ENCODING, 31'(ENC_NO_BODY));
    fresh = 1'b1;
    put(8'h30);
    write_reg(CFG_BODY_ENCODING, 31'(ENC_RESERVED));
    fresh = 1'b1;
    put(8'h31);

    // random: three idling profiles
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin tx_idle_pct = 28; rx_idle_pct = 86; end
        1: begin tx_idle_pct = 86; rx_idle_pct = 28; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      if (p == 2) begin
        // long hold-off while bytes keep coming: the block must fill and
        // stall its input
        use_reg(CFG_BODY_ENCODING, 31'(ENC_IDENTITY));
        use_reg(CFG_PAYLOAD_LEN, 31'd24);
        hold_cycles = 120;
        fresh = 1'b1;
        repeat (24) put(8'($urandom_range(255)));
      end
      goal = sb.live_bytes + 250;
      while (sb.live_bytes < goal) random_body();
    end

    settle();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("http_body_deframer: match");
    end else begin
      $display("http_body_deframer: mismatch");
    end
    $finish;
  end

endmodule
